// File: hdl/bass_shelving_filter_top_macros.svh
`ifndef BASS_SHELVING_FILTER_TOP_MACROS_SVH
`define BASS_SHELVING_FILTER_TOP_MACROS_SVH

// same-cycle implication on clk_i, off during reset
`define BSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsf check failed");

// next-cycle implication on clk_i, off during reset
`define BSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsf check failed");

`endif

// File: hdl/bsf_pkg.sv
package bsf_pkg;

  localparam int MaxChannels = 8;
  localparam int ChW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  localparam logic [16:0] AlphaQ16    = 17'd19661;
  localparam logic [15:0] UnityQ14    = 16'd16384;
  localparam logic [15:0] RampStepRst = 16'd16;

  // configuration register indexes
  localparam logic [1:0] CfgGainTarget = 2'd0;
  localparam logic [1:0] CfgRampStep   = 2'd1;
  localparam logic [1:0] CfgNearUnity  = 2'd2;

  // microprogram addresses
  localparam logic [2:0] UpLoad   = 3'd0;
  localparam logic [2:0] UpMulA   = 3'd1;
  localparam logic [2:0] UpUpdate = 3'd2;
  localparam logic [2:0] UpMulG   = 3'd3;
  localparam logic [2:0] UpEmit   = 3'd4;

  typedef struct packed {
    logic       ld_diff;
    logic       mul_en;
    logic       mul_gain;
    logic       lp_wr;
    logic       emit;
    logic       br_bypass;
    logic [2:0] nxt;
  } bsf_uop_t;

  typedef struct packed {
    logic accept;
    logic ld_diff;
    logic mul_en;
    logic mul_gain;
    logic lp_wr;
    logic emit;
  } bsf_ctrl_t;

  function automatic bsf_uop_t ucode(input logic [2:0] pc);
    bsf_uop_t u;
    u = '0;
    case (pc)
      UpLoad: begin
        u.ld_diff   = 1'b1;
        u.br_bypass = 1'b1;
        u.nxt       = UpMulA;
      end
      UpMulA: begin
        u.mul_en = 1'b1;
        u.nxt    = UpUpdate;
      end
      UpUpdate: begin
        u.lp_wr = 1'b1;
        u.nxt   = UpMulG;
      end
      UpMulG: begin
        u.mul_en   = 1'b1;
        u.mul_gain = 1'b1;
        u.nxt      = UpEmit;
      end
      UpEmit: begin
        u.emit = 1'b1;
        u.nxt  = UpLoad;
      end
      default: begin
        u.nxt = UpLoad;
      end
    endcase
    return u;
  endfunction

endpackage

// File: hdl/bsf_datapath.sv
module bsf_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsf_pkg::bsf_ctrl_t  ctrl_i,
  input  logic signed [15:0]  sample_in_i,
  input  logic [2:0]          channel_i,
  input  logic [15:0]         gain_target_i,
  input  logic [15:0]         ramp_step_i,
  input  logic                near_unity_i,
  output logic                bypass_o,
  output logic signed [15:0]  sample_out_o
);

  logic signed [15:0]       x_q;
  logic [bsf_pkg::ChW-1:0]  ch_q;
  logic [bsf_pkg::ChW-1:0]  ch_wrap;
  logic signed [23:0]       lp_q [bsf_pkg::MaxChannels];
  logic [15:0]              gain_q, gain_d;
  logic                     bypass_q;
  logic signed [24:0]       d_q, d_d;
  logic signed [23:0]       lp_new_q, lp_sum;
  logic signed [24:0]       hp_q, hp_d;
  logic signed [41:0]       prod_q, prod;
  logic signed [15:0]       y_q, y_sat;

  logic signed [23:0] xs;
  logic signed [23:0] lp_cur;
  logic               bypass;
  logic [15:0]        room_up, room_dn;
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] rnd;
  logic signed [25:0] lp_step;
  logic signed [42:0] acc, acc_adj;
  logic signed [20:0] y_full;

  assign ch_wrap = bsf_pkg::ChW'(7'(channel_i) % 7'(bsf_pkg::MaxChannels));
  assign xs      = {x_q, 8'd0};
  assign lp_cur  = lp_q[ch_q];
  assign bypass  = (gain_q == gain_target_i) && near_unity_i;
  assign bypass_o = bypass;

  // linear gain ramp, clamped at the target
  assign room_up = gain_target_i - gain_q;
  assign room_dn = gain_q - gain_target_i;
  always_comb begin
    gain_d = gain_q;
    if (gain_q < gain_target_i) begin
      gain_d = gain_q + ((ramp_step_i < room_up) ? ramp_step_i : room_up);
    end else if (gain_q > gain_target_i) begin
      gain_d = gain_q - ((ramp_step_i < room_dn) ? ramp_step_i : room_dn);
    end
  end

  assign d_d = {xs[23], xs} - {lp_cur[23], lp_cur};

  // shared multiplier
  assign mul_a = ctrl_i.mul_gain ? {lp_new_q[23], lp_new_q} : d_q;
  assign mul_b = ctrl_i.mul_gain ? {1'b0, gain_q} : $signed(bsf_pkg::AlphaQ16);
  assign prod  = mul_a * mul_b;

  // round to nearest, ties away from zero
  assign rnd     = prod_q + (prod_q[41] ? 42'sd32767 : 42'sd32768);
  assign lp_step = rnd[41:16];
  assign lp_sum  = lp_cur + lp_step[23:0];
  assign hp_d    = {xs[23], xs} - {lp_sum[23], lp_sum};

  // truncate toward zero, then saturate
  assign acc     = {prod_q[41], prod_q} + {{4{hp_q[24]}}, hp_q, 14'd0};
  assign acc_adj = acc[42] ? (acc + 43'sh3FFFFF) : acc;
  assign y_full  = acc_adj[42:22];
  always_comb begin
    if (y_full > 21'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (y_full < -21'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_full[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= bsf_pkg::UnityQ14;
      for (int i = 0; i < bsf_pkg::MaxChannels; i++) begin
        lp_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.ld_diff && !bypass) begin
        gain_q <= gain_d;
      end
      if (ctrl_i.lp_wr) begin
        lp_q[ch_q] <= lp_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      x_q  <= sample_in_i;
      ch_q <= ch_wrap;
    end
    if (ctrl_i.ld_diff) begin
      bypass_q <= bypass;
      d_q      <= d_d;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod;
    end
    if (ctrl_i.lp_wr) begin
      lp_new_q <= lp_sum;
      hp_q     <= hp_d;
    end
    if (ctrl_i.emit) begin
      y_q <= bypass_q ? x_q : y_sat;
    end
  end

  assign sample_out_o = y_q;

endmodule

// File: hdl/bass_shelving_filter_top.sv
// Each accepted request runs the microprogram; in bypass it branches from load straight to emit.
// One request in flight: a new request is taken only once the five-step microprogram around
// the single shared 25x17 multiplier has emitted the previous result.
// The output register lets the next request in while a result waits.
// Reset (async, active low): low-pass states 0, gain 1.0, registers to defaults.
module bass_shelving_filter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_in_i,
  input  logic [2:0]         channel_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_out_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0] gain_target_q, ramp_step_q;
  logic        near_unity_q;
  logic        busy_q, busy_d;
  logic [2:0]  pc_q, pc_d;
  logic        out_valid_q, out_valid_d;
  logic        accept, advance, bypass;

  bsf_pkg::bsf_uop_t  uop;
  bsf_pkg::bsf_ctrl_t ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_target_q <= bsf_pkg::UnityQ14;
      ramp_step_q   <= bsf_pkg::RampStepRst;
      near_unity_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsf_pkg::CfgGainTarget: gain_target_q <= cfg_data_i;
        bsf_pkg::CfgRampStep:   ramp_step_q   <= cfg_data_i;
        bsf_pkg::CfgNearUnity:  near_unity_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign uop     = bsf_pkg::ucode(pc_q);
  assign accept  = in_valid_i && !busy_q;
  // emit waits for the output register to free up
  assign advance = busy_q && !(uop.emit && out_valid_q && out_stall_i);

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = bsf_pkg::UpLoad;
    end else if (advance) begin
      if (uop.br_bypass && bypass) begin
        pc_d = bsf_pkg::UpEmit;
      end else if (uop.emit) begin
        busy_d      = 1'b0;
        pc_d        = bsf_pkg::UpLoad;
        out_valid_d = 1'b1;
      end else begin
        pc_d = uop.nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= bsf_pkg::UpLoad;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    ctrl          = '0;
    ctrl.accept   = accept;
    ctrl.ld_diff  = advance && uop.ld_diff;
    ctrl.mul_en   = advance && uop.mul_en;
    ctrl.mul_gain = uop.mul_gain;
    ctrl.lp_wr    = advance && uop.lp_wr;
    ctrl.emit     = advance && uop.emit;
  end

  bsf_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .sample_in_i   (sample_in_i),
    .channel_i     (channel_i),
    .gain_target_i (gain_target_q),
    .ramp_step_i   (ramp_step_q),
    .near_unity_i  (near_unity_q),
    .bypass_o      (bypass),
    .sample_out_o  (sample_out_o)
  );

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/bsf_checker.sv
`include "bass_shelving_filter_top_macros.svh"

module bsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] sample_out_o
);

  // one request in flight: taking one closes the input
  `BSF_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // taking a request does not by itself raise a result
  `BSF_ASSERT_NXT(a_no_early_result, in_valid_i && !in_stall_o, !$rose(out_valid_o))

  // a new result only closes out a request in flight
  `BSF_ASSERT_IMP(a_result_needs_request, $rose(out_valid_o), $past(in_stall_o))

  `BSF_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
                  out_valid_o && $stable(sample_out_o))

endmodule

bind bass_shelving_filter_top bsf_checker u_bsf_checker (.*);

// File: verif/bass_shelving_filter_top_tb.sv
`timescale 1ns / 1ps

module bass_shelving_filter_top_tb;

  localparam logic [1:0] CfgUnused  = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         SettleCycles = 8;

  typedef struct {
    logic signed [15:0] sample;
    logic [2:0]         chan;
  } request_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] sample_in_i = '0;
  logic [2:0]         channel_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] sample_out_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_data_i = '0;

  bass_shelving_filter_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .channel_i   (channel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // filter state mirror
  logic signed [23:0] lp_state [bsf_pkg::MaxChannels];
  logic [15:0]        gain_now;
  logic [15:0]        gain_tgt;
  logic [15:0]        ramp_amt;
  logic               bypass_en;

  request_t           pending_requests [$];
  logic signed [15:0] expected_samples [$];
  request_t           next_req;

  int idle_pct = 29;
  int stall_pct = 29;
  int errors = 0;
  int requests_taken = 0;
  int results_checked = 0;
  int bypass_hits = 0;
  int clip_hits = 0;
  int cfg_writes = 0;
  int cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] shelf_predict(input logic signed [15:0] x,
                                                       input logic [2:0] ch);
    longint      xs, lpv, diff, prod, nudge, acc, y, g, alpha, unity;
    logic [15:0] room;
    if (gain_now == gain_tgt && bypass_en) begin
      bypass_hits++;
      return x;
    end
    if (gain_now < gain_tgt) begin
      room = gain_tgt - gain_now;
      gain_now = gain_now + ((ramp_amt < room) ? ramp_amt : room);
    end else if (gain_now > gain_tgt) begin
      room = gain_now - gain_tgt;
      gain_now = gain_now - ((ramp_amt < room) ? ramp_amt : room);
    end
    alpha = bsf_pkg::AlphaQ16;
    unity = bsf_pkg::UnityQ14;
    g = gain_now;
    xs = x;
    xs = xs * 256;
    lpv = lp_state[ch];
    diff = xs - lpv;
    prod = diff * alpha;
    nudge = (prod >= 0) ? (prod + 32768) / 65536 : (prod - 32768) / 65536;
    lpv = lpv + nudge;
    lp_state[ch] = lpv[23:0];
    lpv = lp_state[ch];
    acc = lpv * g + (xs - lpv) * unity;
    y = acc / (longint'(1) << 22);
    if (y > 32767) begin
      y = 32767;
      clip_hits++;
    end else if (y < -32768) begin
      y = -32768;
      clip_hits++;
    end
    return y[15:0];
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_samples.push_back(shelf_predict(sample_in_i, channel_i));
        requests_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          sample_in_i <= next_req.sample;
          channel_i <= next_req.chan;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: no result expected, got %0d", sample_out_o);
          errors++;
        end else begin
          if (sample_out_o !== expected_samples[0]) begin
            $error("sample_out: expected %0d, got %0d", expected_samples[0], sample_out_o);
            errors++;
          end
          void'(expected_samples.pop_front());
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL bass_shelving_filter_top");
      $finish;
    end
  end

  task automatic add_req(input logic signed [15:0] sample, input logic [2:0] chan);
    request_t r;
    r.sample = sample;
    r.chan = chan;
    pending_requests.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid_i || expected_samples.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bsf_pkg::CfgGainTarget: gain_tgt = data;
      bsf_pkg::CfgRampStep:   ramp_amt = data;
      bsf_pkg::CfgNearUnity:  bypass_en = data[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(3))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  // runs of a held value on one channel drive the low-pass toward the held value
  task automatic queue_random(input int count);
    logic signed [15:0] held;
    logic [2:0]         held_ch;
    int                 run_left;
    held = '0;
    held_ch = '0;
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left > 0) begin
        add_req(held, held_ch);
        run_left--;
      end else begin
        case ($urandom_range(9))
          0, 1: begin
            held = ($urandom_range(1) != 0) ? pick_extreme() : 16'($urandom);
            held_ch = 3'($urandom_range(7));
            run_left = $urandom_range(40, 5);
            add_req(held, held_ch);
          end
          2: add_req(pick_extreme(), 3'($urandom_range(7)));
          default: add_req(16'($urandom), 3'($urandom_range(7)));
        endcase
      end
    end
  endtask

  task automatic random_settings();
    logic [15:0] g, s;
    case ($urandom_range(5))
      0: g = 16'd0;
      1: g = 16'hFFFF;
      2: g = bsf_pkg::UnityQ14;
      default: g = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(7))
      0: s = 16'd0;
      1: s = 16'hFFFF;
      2, 3: s = 16'($urandom_range(65535));
      default: s = 16'($urandom_range(64, 1));
    endcase
    write_reg(bsf_pkg::CfgGainTarget, g);
    write_reg(bsf_pkg::CfgRampStep, s);
    write_reg(bsf_pkg::CfgNearUnity, 16'($urandom));
    if ($urandom_range(3) == 0)
      write_reg(CfgUnused, 16'($urandom));
  endtask

  initial begin
    for (int c = 0; c < bsf_pkg::MaxChannels; c++)
      lp_state[c] = '0;
    gain_now = bsf_pkg::UnityQ14;
    gain_tgt = bsf_pkg::UnityQ14;
    ramp_amt = bsf_pkg::RampStepRst;
    bypass_en = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: settled at unity, so everything passes through
    add_req(16'sd32767, 3'd0);
    add_req(-16'sd32768, 3'd1);
    add_req(16'sd0, 3'd2);
    add_req(-16'sd1, 3'd3);
    add_req(16'sh5555, 3'd4);
    add_req(-16'sd21846, 3'd5);
    wait_idle();

    // full step to zero gain, then bypass once settled
    write_reg(bsf_pkg::CfgGainTarget, 16'd0);
    write_reg(bsf_pkg::CfgRampStep, 16'hFFFF);
    write_reg(bsf_pkg::CfgNearUnity, 16'd1);
    add_req(16'sd32767, 3'd6);
    add_req(16'sd32767, 3'd6);
    add_req(-16'sd32768, 3'd7);
    wait_idle();

    // zero step: gain stuck at zero below the target
    write_reg(bsf_pkg::CfgNearUnity, 16'd0);
    write_reg(bsf_pkg::CfgRampStep, 16'd0);
    write_reg(bsf_pkg::CfgGainTarget, 16'hFFFF);
    for (int c = 0; c < bsf_pkg::MaxChannels; c++)
      add_req((c % 2 != 0) ? -16'sd32768 : 16'sd32767, 3'(c));
    wait_idle();

    // jump to max gain, push both rails into clipping
    write_reg(bsf_pkg::CfgRampStep, 16'hFFFF);
    repeat (4) add_req(16'sd32767, 3'd0);
    repeat (4) add_req(-16'sd32768, 3'd1);
    wait_idle();
    write_reg(CfgUnused, 16'hFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph == 3) ? 0 : 29;
      stall_pct = (ph == 3) ? 0 : 29;
      random_settings();
      queue_random(125);
      wait_idle();
    end

    $display("Ran %0d requests, checked %0d results over %0d register writes.",
             requests_taken, results_checked, cfg_writes);
    $display("Bypassed %0d samples, %0d outputs clipped at the rails.",
             bypass_hits, clip_hits);
    if (errors == 0) begin
      $display("PASS bass_shelving_filter_top");
    end else begin
      $display("FAIL bass_shelving_filter_top");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/bsf_pkg.sv
hdl/bsf_datapath.sv
hdl/bass_shelving_filter_top.sv
hdl/bsf_checker.sv
verif/bass_shelving_filter_top_tb.sv
